### rtl/crs_pkg.sv
package crs_pkg;

	localparam int SLOTS = 128;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int SLOT_W = 7;
	localparam int PAD_W = (SLOT_W > IDX_W) ? SLOT_W : IDX_W;

	localparam int REC_BYTES = 9;
	localparam logic [7:0] CRC_POLY = 8'h07;
	localparam logic [7:0] CRC_INIT = 8'hFF;

	localparam logic [1:0] OP_RESTORE = 2'd0;
	localparam logic [1:0] OP_SAVE = 2'd1;
	localparam logic [1:0] OP_FORCE = 2'd2;
	localparam logic [1:0] OP_NONE = 2'd3;

	localparam logic [2:0] ST_RESTORED = 3'd0;
	localparam logic [2:0] ST_CORRUPT = 3'd1;
	localparam logic [2:0] ST_WRITTEN = 3'd2;
	localparam logic [2:0] ST_WRITTEN_ERASED = 3'd3;
	localparam logic [2:0] ST_SKIPPED = 3'd4;

	localparam int ACT_W = 4;
	localparam logic [ACT_W-1:0] ACT_NONE = 4'd0;
	localparam logic [ACT_W-1:0] ACT_TAKE = 4'd1;
	localparam logic [ACT_W-1:0] ACT_SCAN_START = 4'd2;
	localparam logic [ACT_W-1:0] ACT_SCAN = 4'd3;
	localparam logic [ACT_W-1:0] ACT_RESTORE = 4'd4;
	localparam logic [ACT_W-1:0] ACT_FEED = 4'd5;
	localparam logic [ACT_W-1:0] ACT_WAIT_CRC = 4'd6;
	localparam logic [ACT_W-1:0] ACT_SKIP = 4'd7;
	localparam logic [ACT_W-1:0] ACT_ERASE = 4'd8;
	localparam logic [ACT_W-1:0] ACT_WRITE = 4'd9;

	typedef struct packed {
		logic [31:0] duty;
		logic [31:0] volt;
		logic [7:0]  flags;
		logic [7:0]  crc;
	} rec_t;

	typedef struct packed {
		logic             vld;
		logic             is_save;
		logic [IDX_W-1:0] idx;
		rec_t             rec;
		logic [7:0]       crc;
	} tag_t;

	typedef struct packed {
		logic go;
		logic restore;
		logic scan_done;
		logic crc_out;
		logic skip;
		logic need_erase;
		logic out_free;
	} cond_t;

	function automatic logic [7:0] crc_byte(input logic [7:0] c, input logic [7:0] b);
		logic [7:0] r;
		r = c ^ b;
		for (int k = 0; k < 8; k++) begin
			r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
		end
		return r;
	endfunction

	function automatic logic [7:0] rec_byte(input rec_t r, input int k);
		logic [71:0] d;
		d = {r.duty, r.volt, r.flags};
		return d[71 - 8 * k -: 8];
	endfunction

	function automatic logic [SLOT_W-1:0] slot_out(input logic [IDX_W-1:0] i);
		logic [PAD_W-1:0] w;
		w = PAD_W'(i);
		return w[SLOT_W-1:0];
	endfunction

endpackage

### rtl/crs_req_if.sv
interface crs_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [31:0] duty_word;
	logic [31:0] volt_word;
	logic [3:0]  flag_bits;

	modport source (output valid, operation, duty_word, volt_word, flag_bits, input ready);
	modport sink (input valid, operation, duty_word, volt_word, flag_bits, output ready);
endinterface

### rtl/crs_rsp_if.sv
interface crs_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] stored_duty;
	logic [31:0] stored_volt;
	logic [3:0]  stored_flags;
	logic [6:0]  slot_used;

	modport source (output valid, status, stored_duty, stored_volt, stored_flags, slot_used,
		input ready);
	modport sink (input valid, status, stored_duty, stored_volt, stored_flags, slot_used,
		output ready);
endinterface

### rtl/crc_checked_rolling_record_store.sv
// Rolling settings record store with CRC-8 per record.
// req (sink): operation 0 restores the latest good record, 1 saves unless the
// record CRC equals the last one written or restored, 2 saves after erasing
// the store. Operation 3 is taken and dropped without a result.
// rsp (source): one item per operation with status, restored fields and slot.
// Restore: the slot memory is read one slot per cycle from slot 0 and each
// record's CRC is checked in a 9-stage byte-wise CRC pipeline; the scan stops
// at the first bad slot. The result is registered once the first bad slot or
// the last slot leaves the pipeline; at most SLOTS slots are checked.
// Save: the record goes once through the CRC pipeline; the result then comes
// from the skip step, or from the write step, after an erase when needed.
// One item is worked on at a time; the next item may be taken in the cycle
// the result shows, while that result may still sit in the output register.
// Reset: slot memory reads as erased (all ones) through per-slot valid bits,
// next slot and last CRC clear; the block is ready at once.
// A stalled receiver holds the result; the block then stops at its next result.
module crc_checked_rolling_record_store (
	input logic      clk,
	input logic      arst_n,
	crs_req_if.sink  req,
	crs_rsp_if.source rsp
);
	import crs_pkg::*;

	logic [ACT_W-1:0] act;
	cond_t            cond;

	logic [1:0]       op_q;
	logic [31:0]      duty_q;
	logic [31:0]      volt_q;
	logic [3:0]       flags_q;
	logic             erased_q;
	logic [7:0]       save_crc_q;
	logic [CNT_W-1:0] addr_q;
	logic [CNT_W-1:0] next_slot_q;
	logic [7:0]       last_crc_q;

	rec_t             best_rec_q;
	logic [IDX_W-1:0] best_idx_q;
	logic             have_ok_q;

	rec_t             mem [SLOTS];
	logic [SLOTS-1:0] slot_vld_q;
	rec_t             rd_rec_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic             rd_hit_s1;
	logic             rd_vld_s1;

	logic             rsp_vld_q;
	logic [2:0]       status_q;
	logic [31:0]      duty_out_q;
	logic [31:0]      volt_out_q;
	logic [3:0]       flags_out_q;
	logic [6:0]       slot_out_q;

	logic             accept;
	logic             out_free;
	logic             rd_en;
	logic [IDX_W-1:0] rd_idx;
	logic             wr_en;
	logic [IDX_W-1:0] wr_idx;
	rec_t             wr_rec;
	logic             feed;
	logic             flush;
	tag_t             pin;
	tag_t             pout;
	logic             pout_ok;
	logic             scan_hit;

	assign req.ready = (act == ACT_TAKE);
	assign accept = req.valid && req.ready;
	assign out_free = !rsp_vld_q || rsp.ready;

	assign rd_en = (act == ACT_SCAN) && (addr_q < CNT_W'(SLOTS));
	assign rd_idx = addr_q[IDX_W-1:0];
	assign wr_en = (act == ACT_WRITE) && out_free;
	assign wr_idx = next_slot_q[IDX_W-1:0];
	assign wr_rec = '{duty: duty_q, volt: volt_q, flags: {4'h0, flags_q}, crc: save_crc_q};
	assign feed = (act == ACT_FEED);
	assign flush = (act == ACT_SCAN_START);

	always_comb begin
		pin.vld = feed || rd_vld_s1;
		pin.is_save = feed;
		pin.idx = feed ? '0 : rd_idx_s1;
		pin.rec = feed ? wr_rec : (rd_hit_s1 ? rd_rec_s1 : '1);
		pin.crc = CRC_INIT;
	end

	crs_crc_pipe u_crc (
		.clk     (clk),
		.arst_n  (arst_n),
		.flush   (flush),
		.in_tag  (pin),
		.out_tag (pout)
	);

	assign pout_ok = (pout.crc == pout.rec.crc);
	assign scan_hit = pout.vld && !pout.is_save;

	always_comb begin
		cond.go = accept && (req.operation != OP_NONE);
		cond.restore = (op_q == OP_RESTORE);
		cond.scan_done = scan_hit && (!pout_ok || pout.idx == IDX_W'(SLOTS - 1));
		cond.crc_out = pout.vld && pout.is_save;
		cond.skip = (op_q != OP_FORCE) && (save_crc_q == last_crc_q);
		cond.need_erase = (op_q == OP_FORCE) || (next_slot_q >= CNT_W'(SLOTS));
		cond.out_free = out_free;
	end

	crs_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cond   (cond),
		.act    (act)
	);

	// slot memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_rec;
		end
		if (rd_en) begin
			rd_rec_s1 <= mem[rd_idx];
			rd_hit_s1 <= slot_vld_q[rd_idx];
			rd_idx_s1 <= rd_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_vld_q <= '0;
			rd_vld_s1 <= 1'b0;
			addr_q <= '0;
			next_slot_q <= '0;
			last_crc_q <= '0;
			have_ok_q <= 1'b0;
			erased_q <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			case (act)
				ACT_TAKE: begin
					if (accept) begin
						erased_q <= 1'b0;
					end
				end
				ACT_SCAN_START: begin
					addr_q <= '0;
					have_ok_q <= 1'b0;
				end
				ACT_SCAN: begin
					if (rd_en) begin
						addr_q <= addr_q + CNT_W'(1);
					end
					if (scan_hit && pout_ok) begin
						have_ok_q <= 1'b1;
					end
				end
				ACT_RESTORE: begin
					if (out_free) begin
						if (have_ok_q) begin
							next_slot_q <= CNT_W'(best_idx_q) + CNT_W'(1);
							last_crc_q <= best_rec_q.crc;
						end else begin
							next_slot_q <= '0;
						end
					end
				end
				ACT_ERASE: begin
					slot_vld_q <= '0;
					next_slot_q <= '0;
					erased_q <= 1'b1;
				end
				ACT_WRITE: begin
					if (wr_en) begin
						slot_vld_q[wr_idx] <= 1'b1;
						next_slot_q <= CNT_W'(wr_idx) + CNT_W'(1);
						last_crc_q <= save_crc_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= req.operation;
			duty_q <= req.duty_word;
			volt_q <= req.volt_word;
			flags_q <= req.flag_bits;
		end
		if (act == ACT_SCAN && scan_hit && pout_ok) begin
			best_rec_q <= pout.rec;
			best_idx_q <= pout.idx;
		end
		if (act == ACT_WAIT_CRC && pout.vld && pout.is_save) begin
			save_crc_q <= pout.crc;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (out_free && (act == ACT_RESTORE || act == ACT_SKIP || act == ACT_WRITE)) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			case (act)
				ACT_RESTORE: begin
					status_q <= have_ok_q ? ST_RESTORED : ST_CORRUPT;
					duty_out_q <= have_ok_q ? best_rec_q.duty : '0;
					volt_out_q <= have_ok_q ? best_rec_q.volt : '0;
					flags_out_q <= have_ok_q ? best_rec_q.flags[3:0] : '0;
					slot_out_q <= have_ok_q ? slot_out(best_idx_q) : '0;
				end
				ACT_SKIP: begin
					status_q <= ST_SKIPPED;
					duty_out_q <= '0;
					volt_out_q <= '0;
					flags_out_q <= '0;
					slot_out_q <= '0;
				end
				ACT_WRITE: begin
					status_q <= erased_q ? ST_WRITTEN_ERASED : ST_WRITTEN;
					duty_out_q <= '0;
					volt_out_q <= '0;
					flags_out_q <= '0;
					slot_out_q <= slot_out(wr_idx);
				end
				default: begin
				end
			endcase
		end
	end

	assign rsp.valid = rsp_vld_q;
	assign rsp.status = status_q;
	assign rsp.stored_duty = duty_out_q;
	assign rsp.stored_volt = volt_out_q;
	assign rsp.stored_flags = flags_out_q;
	assign rsp.slot_used = slot_out_q;

`ifndef SYNTHESIS
	a_next_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		next_slot_q <= CNT_W'(SLOTS))
		else $error("next slot beyond store size");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (next_slot_q < CNT_W'(SLOTS)))
		else $error("slot write with full store");

	a_save_crc_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		(pout.vld && pout.is_save) |-> (act == ACT_WAIT_CRC))
		else $error("save CRC arrived outside its wait step");

	a_scan_read_order: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |=> (addr_q == $past(addr_q) + CNT_W'(1)))
		else $error("scan address did not advance");
`endif

endmodule

### rtl/crs_crc_pipe.sv
module crs_crc_pipe (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          flush,
	input  crs_pkg::tag_t in_tag,
	output crs_pkg::tag_t out_tag
);
	import crs_pkg::*;

	// one record byte per stage
	tag_t                 pipe_s [REC_BYTES];
	tag_t                 stage_d [REC_BYTES];
	logic [REC_BYTES-1:0] vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (flush) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[REC_BYTES-2:0], in_tag.vld};
		end
	end

	always_comb begin
		stage_d[0] = in_tag;
		stage_d[0].crc = crc_byte(in_tag.crc, rec_byte(in_tag.rec, 0));
		for (int k = 1; k < REC_BYTES; k++) begin
			stage_d[k] = pipe_s[k-1];
			stage_d[k].crc = crc_byte(pipe_s[k-1].crc, rec_byte(pipe_s[k-1].rec, k));
		end
	end

	always_ff @(posedge clk) begin
		pipe_s <= stage_d;
	end

	always_comb begin
		out_tag = pipe_s[REC_BYTES-1];
		out_tag.vld = vld_s[REC_BYTES-1];
	end

endmodule

### rtl/crs_seq.sv
module crs_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  crs_pkg::cond_t              cond,
	output logic [crs_pkg::ACT_W-1:0]   act
);
	import crs_pkg::*;

	localparam int PC_W = 4;

	localparam logic [PC_W-1:0] STEP_WAIT = 4'd0;
	localparam logic [PC_W-1:0] STEP_DISPATCH = 4'd1;
	localparam logic [PC_W-1:0] STEP_SCAN_INIT = 4'd2;
	localparam logic [PC_W-1:0] STEP_SCAN = 4'd3;
	localparam logic [PC_W-1:0] STEP_RESULT = 4'd4;
	localparam logic [PC_W-1:0] STEP_FEED = 4'd5;
	localparam logic [PC_W-1:0] STEP_CRC_WAIT = 4'd6;
	localparam logic [PC_W-1:0] STEP_DECIDE = 4'd7;
	localparam logic [PC_W-1:0] STEP_SKIP = 4'd8;
	localparam logic [PC_W-1:0] STEP_ERASE_CHK = 4'd9;
	localparam logic [PC_W-1:0] STEP_ERASE = 4'd10;
	localparam logic [PC_W-1:0] STEP_WRITE = 4'd11;

	localparam int COND_W = 3;
	localparam logic [COND_W-1:0] COND_ALWAYS = 3'd0;
	localparam logic [COND_W-1:0] COND_GO = 3'd1;
	localparam logic [COND_W-1:0] COND_RESTORE = 3'd2;
	localparam logic [COND_W-1:0] COND_SCAN_DONE = 3'd3;
	localparam logic [COND_W-1:0] COND_CRC_OUT = 3'd4;
	localparam logic [COND_W-1:0] COND_SKIP = 3'd5;
	localparam logic [COND_W-1:0] COND_NEED_ERASE = 3'd6;
	localparam logic [COND_W-1:0] COND_OUT_FREE = 3'd7;

	typedef struct packed {
		logic [ACT_W-1:0]  act;
		logic [COND_W-1:0] sel;
		logic [PC_W-1:0]   t_true;
		logic [PC_W-1:0]   t_false;
	} uword_t;

	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		case (pc)
			STEP_WAIT:      return '{ACT_TAKE, COND_GO, STEP_DISPATCH, STEP_WAIT};
			STEP_DISPATCH:  return '{ACT_NONE, COND_RESTORE, STEP_SCAN_INIT, STEP_FEED};
			STEP_SCAN_INIT: return '{ACT_SCAN_START, COND_ALWAYS, STEP_SCAN, STEP_SCAN};
			STEP_SCAN:      return '{ACT_SCAN, COND_SCAN_DONE, STEP_RESULT, STEP_SCAN};
			STEP_RESULT:    return '{ACT_RESTORE, COND_OUT_FREE, STEP_WAIT, STEP_RESULT};
			STEP_FEED:      return '{ACT_FEED, COND_ALWAYS, STEP_CRC_WAIT, STEP_CRC_WAIT};
			STEP_CRC_WAIT:  return '{ACT_WAIT_CRC, COND_CRC_OUT, STEP_DECIDE, STEP_CRC_WAIT};
			STEP_DECIDE:    return '{ACT_NONE, COND_SKIP, STEP_SKIP, STEP_ERASE_CHK};
			STEP_SKIP:      return '{ACT_SKIP, COND_OUT_FREE, STEP_WAIT, STEP_SKIP};
			STEP_ERASE_CHK: return '{ACT_NONE, COND_NEED_ERASE, STEP_ERASE, STEP_WRITE};
			STEP_ERASE:     return '{ACT_ERASE, COND_ALWAYS, STEP_WRITE, STEP_WRITE};
			STEP_WRITE:     return '{ACT_WRITE, COND_OUT_FREE, STEP_WAIT, STEP_WRITE};
			default:        return '{ACT_NONE, COND_ALWAYS, STEP_WAIT, STEP_WAIT};
		endcase
	endfunction

	logic [PC_W-1:0] pc_q;
	uword_t          word;
	logic            taken;

	always_comb begin
		word = ucode(pc_q);
		case (word.sel)
			COND_ALWAYS:     taken = 1'b1;
			COND_GO:         taken = cond.go;
			COND_RESTORE:    taken = cond.restore;
			COND_SCAN_DONE:  taken = cond.scan_done;
			COND_CRC_OUT:    taken = cond.crc_out;
			COND_SKIP:       taken = cond.skip;
			COND_NEED_ERASE: taken = cond.need_erase;
			COND_OUT_FREE:   taken = cond.out_free;
			default:         taken = 1'b0;
		endcase
	end

	assign act = word.act;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_WAIT;
		end else begin
			pc_q <= taken ? word.t_true : word.t_false;
		end
	end

endmodule

### test/crs_test_pkg.sv
package crs_test_pkg;

	import crs_pkg::*;

	// CRC-8 over duty, volt and flag byte, bit-serial, MSB first
	function automatic logic [7:0] record_check_crc(input logic [31:0] duty,
		input logic [31:0] volt, input logic [7:0] flags);
		logic [71:0] bits;
		logic [7:0]  crc;
		logic        fb;
		bits = {duty, volt, flags};
		crc = CRC_INIT;
		for (int k = 71; k >= 0; k--) begin
			fb = crc[7] ^ bits[k];
			crc = {crc[6:0], 1'b0};
			if (fb) begin
				crc = crc ^ CRC_POLY;
			end
		end
		return crc;
	endfunction

endpackage

### test/crs_store_checker.sv
module crs_store_checker (
	input  logic clk,
	input  logic arst_n,
	crs_req_if   req,
	crs_rsp_if   rsp,
	output int   fail_count,
	output int   open_results
);
	timeunit 1ns;
	timeprecision 1ps;

	import crs_pkg::*;
	import crs_test_pkg::*;

	typedef struct {
		logic [2:0]  status;
		logic [31:0] duty;
		logic [31:0] volt;
		logic [3:0]  flags;
		logic [6:0]  slot;
	} store_result_t;

	rec_t          slot_image [SLOTS];
	int            next_write_slot;
	logic [7:0]    last_written_crc;
	store_result_t expected_results [$];

	function automatic bit slot_intact(input int i);
		return record_check_crc(slot_image[i].duty, slot_image[i].volt,
			slot_image[i].flags) == slot_image[i].crc;
	endfunction

	task automatic erase_image();
		foreach (slot_image[i]) begin
			slot_image[i] = '1;
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	task automatic predict_store_op(input logic [1:0] op, input logic [31:0] duty,
		input logic [31:0] volt, input logic [3:0] flags);
		store_result_t res;
		logic [7:0]    crc;
		int            i;
		res = '{default: '0};
		if (op == OP_NONE) begin
			return;
		end
		if (op == OP_RESTORE) begin
			i = 0;
			while (i < SLOTS && slot_intact(i)) begin
				i++;
			end
			if (i > 0) begin
				i--;
			end
			if (slot_intact(i)) begin
				res.status = ST_RESTORED;
				res.duty = slot_image[i].duty;
				res.volt = slot_image[i].volt;
				res.flags = slot_image[i].flags[3:0];
				res.slot = 7'(i);
				last_written_crc = slot_image[i].crc;
				next_write_slot = i + 1;
			end else begin
				res.status = ST_CORRUPT;
				next_write_slot = i;
			end
		end else begin
			crc = record_check_crc(duty, volt, {4'h0, flags});
			if (op == OP_SAVE && crc == last_written_crc) begin
				res.status = ST_SKIPPED;
			end else begin
				res.status = ST_WRITTEN;
				if (op == OP_FORCE || next_write_slot >= SLOTS) begin
					erase_image();
					next_write_slot = 0;
					res.status = ST_WRITTEN_ERASED;
				end
				slot_image[next_write_slot] = '{duty, volt, {4'h0, flags}, crc};
				res.slot = 7'(next_write_slot);
				last_written_crc = crc;
				next_write_slot++;
			end
		end
		expected_results.push_back(res);
	endtask

	always @(posedge clk or negedge arst_n) begin
		store_result_t want;
		if (!arst_n) begin
			erase_image();
			next_write_slot = 0;
			last_written_crc = '0;
			expected_results.delete();
			fail_count = 0;
			open_results = 0;
		end else begin
			// results leave before the item taken at this edge can produce one
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result item: status 0x%0h slot %0d",
						rsp.status, rsp.slot_used);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("status", 32'(want.status), 32'(rsp.status));
					check_field("stored_duty", want.duty, rsp.stored_duty);
					check_field("stored_volt", want.volt, rsp.stored_volt);
					check_field("stored_flags", 32'(want.flags), 32'(rsp.stored_flags));
					check_field("slot_used", 32'(want.slot), 32'(rsp.slot_used));
				end
			end
			if (req.valid && req.ready) begin
				predict_store_op(req.operation, req.duty_word, req.volt_word, req.flag_bits);
			end
			open_results = expected_results.size();
		end
	end

endmodule

### test/crc_checked_rolling_record_store_test.sv
module crc_checked_rolling_record_store_test;
	timeunit 1ns;
	timeprecision 1ps;

	import crs_pkg::*;
	import crs_test_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASE_ITEMS = 100;
	localparam int LONG_HOLD = 400;
	localparam int TAIL_CYCLES = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   open_results;
	int   cycle_count = 0;
	int   phase = 0;
	int   tx_idle_pct = 0;
	int   rx_stall_pct = 0;

	// stimulus-side view of the store, used to steer toward a full store
	int          writes_since_erase = 0;
	bit          full_checked = 0;
	logic [7:0]  last_saved_crc = '0;
	logic [31:0] last_duty = '0;
	logic [31:0] last_volt = '0;
	logic [3:0]  last_flags = '0;

	crs_req_if req ();
	crs_rsp_if rsp ();

	crc_checked_rolling_record_store i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	crs_store_checker i_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.rsp          (rsp),
		.fail_count   (fail_count),
		.open_results (open_results)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("crc_checked_rolling_record_store_test: FAIL");
			$finish;
		end
	end

	task automatic issue(input logic [1:0] op, input logic [31:0] duty,
		input logic [31:0] volt, input logic [3:0] flags);
		logic [7:0] crc;
		crc = record_check_crc(duty, volt, {4'h0, flags});
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.operation <= op;
		req.duty_word <= duty;
		req.volt_word <= volt;
		req.flag_bits <= flags;
		@(posedge clk);
		while (!req.ready) begin
			@(posedge clk);
		end
		if (op == OP_FORCE || (op == OP_SAVE && crc != last_saved_crc)) begin
			if (op == OP_FORCE || writes_since_erase >= SLOTS) begin
				writes_since_erase = 1;
			end else begin
				writes_since_erase++;
			end
			full_checked = 0;
			last_saved_crc = crc;
			last_duty = duty;
			last_volt = volt;
			last_flags = flags;
		end
	endtask

	// new record whose CRC differs from the last one saved
	task automatic draw_record(output logic [31:0] duty, output logic [31:0] volt,
		output logic [3:0] flags);
		do begin
			duty = $urandom;
			volt = $urandom;
			flags = 4'($urandom_range(0, 15));
		end while (record_check_crc(duty, volt, {4'h0, flags}) == last_saved_crc);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (open_results != 0) begin
			@(posedge clk);
		end
	endtask

	initial begin
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 0;
		rsp.ready <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (phase == 2 && !hold_done) begin
				hold_done = 1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
			end
		end
	end

	initial begin
		logic [31:0] d;
		logic [31:0] v;
		logic [3:0]  f;
		int          r;
		int          n;
		req.valid <= 1'b0;
		req.operation <= OP_RESTORE;
		req.duty_word <= '0;
		req.volt_word <= '0;
		req.flag_bits <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty store reads back corrupt
		issue(OP_RESTORE, 32'h0, 32'h0, 4'h0);
		// a record with CRC 0 is skipped on a fresh store
		d = 32'h1234_5678;
		f = 4'h9;
		v = 32'hA5A5_A500;
		while (record_check_crc(d, v, {4'h0, f}) != 8'h00) begin
			v++;
		end
		issue(OP_SAVE, d, v, f);
		issue(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);
		issue(OP_SAVE, 32'h0, 32'h0, 4'h0);
		issue(OP_SAVE, 32'h0, 32'h0, 4'h0);
		issue(OP_RESTORE, 32'h0, 32'h0, 4'h0);
		issue(OP_SAVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);
		issue(OP_RESTORE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);
		issue(OP_FORCE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);
		issue(OP_SAVE, 32'h8000_0000, 32'h0000_0001, 4'h1);
		issue(OP_SAVE, 32'h0000_0001, 32'h8000_0000, 4'h2);
		issue(OP_SAVE, 32'hAAAA_AAAA, 32'h5555_5555, 4'h4);
		issue(OP_SAVE, 32'h5555_5555, 32'hAAAA_AAAA, 4'h8);
		issue(OP_RESTORE, 32'h0, 32'h0, 4'h0);
		issue(OP_SAVE, 32'h5555_5555, 32'hAAAA_AAAA, 4'h8);
		issue(OP_FORCE, d, v, f);
		issue(OP_NONE, 32'h0, 32'h0, 4'h0);
		issue(OP_RESTORE, 32'h0, 32'h0, 4'h0);
		issue(OP_FORCE, 32'hAAAA_AAAA, 32'h5555_5555, 4'hA);
		drain();

		for (int p = 0; p < 4; p++) begin
			phase = p;
			case (p)
				0: begin
					tx_idle_pct = 0;
					rx_stall_pct = 0;
				end
				1: begin
					tx_idle_pct = 47;
					rx_stall_pct = 0;
				end
				2: begin
					tx_idle_pct = 0;
					rx_stall_pct = 47;
				end
				default: begin
					tx_idle_pct = 30;
					rx_stall_pct = 30;
				end
			endcase
			n = 0;
			while (n < PHASE_ITEMS) begin
				r = $urandom_range(0, 99);
				if (writes_since_erase == SLOTS && !full_checked) begin
					// every slot valid: restore must report the top slot
					full_checked = 1;
					issue(OP_RESTORE, $urandom, $urandom, 4'($urandom_range(0, 15)));
					n++;
				end else if (r < 10) begin
					issue(OP_RESTORE, $urandom, $urandom, 4'($urandom_range(0, 15)));
					n++;
				end else if (r < 16) begin
					issue(OP_NONE, $urandom, $urandom, 4'($urandom_range(0, 15)));
				end else if (r < 21) begin
					issue(OP_SAVE, last_duty, last_volt, last_flags);
					n++;
				end else if (r < 25 && p >= 2) begin
					draw_record(d, v, f);
					issue(OP_FORCE, d, v, f);
					n++;
				end else begin
					draw_record(d, v, f);
					issue(OP_SAVE, d, v, f);
					n++;
				end
			end
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && open_results == 0) begin
			$display("crc_checked_rolling_record_store_test: PASS");
		end else begin
			$display("crc_checked_rolling_record_store_test: FAIL");
		end
		$finish;
	end

endmodule
